// ----- hdl/i2cbb_pkg.sv -----
// Shared types and constants of the I2C bit-bang master.
`default_nettype none
package i2cbb_pkg;

	// Command codes carried by an input item
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

	localparam int CFG_DATA_W = 16;
	localparam logic [15:0] UNIT_TICKS_RST  = 16'd50;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

	typedef struct packed {
		logic [15:0] unit_ticks;
		logic [15:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       ack_mode;
		logic       sda_in;
	} in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_ok;
	} out_t;

endpackage
`default_nettype wire

// ----- hdl/i2c_bitbang_master_top.sv -----
// The result of an item is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle while the result side takes results; the sequencer's next-state
// logic is combinational and the result register refills on the edge its item is taken.
// Reset (arst_n low, asynchronous): bus idle with SCL and SDA driven high, ack_ok 1,
// registers at 50 ticks per unit and a timeout of 1000, no result pending.
`default_nettype none
module i2c_bitbang_master_top
	import i2cbb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	out_t res;
	logic step;

	// Accept when the result register is empty or being emptied
	assign in_ready = !out_valid || out_ready;
	assign step     = in_valid && in_ready;

	i2cbb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cbb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (in_data),
		.res    (res)
	);

	i2cbb_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ----- hdl/i2cbb_cfg.sv -----
// Configuration registers of the I2C bit-bang master.
`default_nettype none
module i2cbb_cfg
	import i2cbb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	logic [15:0] unit_ticks_q;
	logic [15:0] ack_timeout_q;

	// Take a register write when enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= UNIT_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_data;
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.unit_ticks  = unit_ticks_q;
	assign cfg.ack_timeout = ack_timeout_q;

endmodule
`default_nettype wire

// ----- hdl/i2cbb_core.sv -----
// Bus phase sequencer: state registers and next-state logic, one tick per item.
`default_nettype none
module i2cbb_core
	import i2cbb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic step,
	input  wire in_t  item,
	output out_t      res
);

	localparam logic [4:0] PH_IDLE    = 5'd0;
	localparam logic [4:0] PH_ST_A    = 5'd1;
	localparam logic [4:0] PH_ST_B    = 5'd2;
	localparam logic [4:0] PH_ST_C    = 5'd3;
	localparam logic [4:0] PH_SP_A    = 5'd4;
	localparam logic [4:0] PH_SP_B    = 5'd5;
	localparam logic [4:0] PH_SP_C    = 5'd6;
	localparam logic [4:0] PH_WR_LOW  = 5'd7;
	localparam logic [4:0] PH_WR_DATA = 5'd8;
	localparam logic [4:0] PH_WR_HIGH = 5'd9;
	localparam logic [4:0] PH_AK_REL  = 5'd10;
	localparam logic [4:0] PH_AK_HIGH = 5'd11;
	localparam logic [4:0] PH_AK_WAIT = 5'd12;
	localparam logic [4:0] PH_AK_LOW  = 5'd13;
	localparam logic [4:0] PH_RD_HIGH = 5'd14;
	localparam logic [4:0] PH_RD_LOW  = 5'd15;
	localparam logic [4:0] PH_RA_DATA = 5'd16;
	localparam logic [4:0] PH_RA_HIGH = 5'd17;
	localparam logic [4:0] PH_RA_LOW  = 5'd18;

	logic [4:0]  phase_q,  n_phase;
	logic [2:0]  bit_q,    n_bit;
	logic [7:0]  shift_q,  n_shift;
	logic [16:0] delay_q,  n_delay;
	logic [16:0] wait_q,   n_wait;
	logic        scl_q,    n_scl;
	logic        sda_q,    n_sda;
	logic        dir_q,    n_dir;
	logic [7:0]  rx_q,     n_rx;
	logic        ack_q,    n_ack;
	logic        ackc_q,   n_ackc;
	logic        done;
	logic        do_enter;
	logic [4:0]  ent;
	logic [16:0] dec;
	logic [16:0] unit1;
	logic [16:0] unit2;

	// Phase lengths of one and two delay units; zero counts as one
	always_comb begin
		unit1 = {1'b0, (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks};
		unit2 = {unit1[15:0], 1'b0};
	end

	// Work out the state after this tick
	always_comb begin
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_delay  = delay_q;
		n_wait   = wait_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_dir    = dir_q;
		n_rx     = rx_q;
		n_ack    = ack_q;
		n_ackc   = ackc_q;
		done     = 1'b0;
		do_enter = 1'b0;
		ent      = PH_IDLE;
		dec      = (delay_q != 17'd0) ? delay_q - 17'd1 : 17'd0;

		if (phase_q == PH_IDLE) begin
			if (item.cmd == CMD_START || item.cmd == CMD_STOP ||
			    item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
				n_bit    = 3'd0;
				n_wait   = 17'd0;
				n_ackc   = item.ack_mode;
				n_ack    = 1'b1;
				n_shift  = (item.cmd == CMD_WRITE) ? item.tx_byte : 8'd0;
				do_enter = 1'b1;
				unique case (item.cmd)
					CMD_START: ent = PH_ST_A;
					CMD_STOP:  ent = PH_SP_A;
					CMD_WRITE: ent = PH_WR_LOW;
					default:   ent = PH_RD_HIGH;
				endcase
			end
		end else if (phase_q == PH_AK_WAIT) begin
			// Watch SDA for the acknowledge, give up past the timeout
			if (!item.sda_in) begin
				do_enter = 1'b1;
				ent      = PH_AK_LOW;
			end else if (wait_q > {1'b0, cfg.ack_timeout}) begin
				n_scl = 1'b0;
				n_ack = 1'b0;
				done  = 1'b1;
			end else begin
				n_wait = wait_q + 17'd1;
			end
		end else begin
			// Count the phase down and advance when it runs out
			n_delay = dec;
			if (dec == 17'd0) begin
				unique case (phase_q)
					PH_ST_A:    begin do_enter = 1'b1; ent = PH_ST_B; end
					PH_ST_B:    begin do_enter = 1'b1; ent = PH_ST_C; end
					PH_SP_A:    begin do_enter = 1'b1; ent = PH_SP_B; end
					PH_SP_B:    begin do_enter = 1'b1; ent = PH_SP_C; end
					PH_WR_LOW:  begin do_enter = 1'b1; ent = PH_WR_DATA; end
					PH_WR_DATA: begin do_enter = 1'b1; ent = PH_WR_HIGH; end
					PH_WR_HIGH: begin
						if (bit_q != 3'd7) begin
							n_bit    = bit_q + 3'd1;
							do_enter = 1'b1;
							ent      = PH_WR_LOW;
						end else begin
							n_scl = 1'b0;
							n_sda = 1'b1;
							if (!ackc_q) begin
								done = 1'b1;
							end else begin
								do_enter = 1'b1;
								ent      = PH_AK_REL;
							end
						end
					end
					PH_AK_REL:  begin do_enter = 1'b1; ent = PH_AK_HIGH; end
					PH_AK_HIGH: begin do_enter = 1'b1; ent = PH_AK_WAIT; end
					PH_RD_HIGH: begin
						n_shift  = {shift_q[6:0], item.sda_in};
						do_enter = 1'b1;
						ent      = PH_RD_LOW;
					end
					PH_RD_LOW: begin
						do_enter = 1'b1;
						if (bit_q != 3'd7) begin
							n_bit = bit_q + 3'd1;
							ent   = PH_RD_HIGH;
						end else begin
							ent = PH_RA_DATA;
						end
					end
					PH_RA_DATA: begin do_enter = 1'b1; ent = PH_RA_HIGH; end
					PH_RA_HIGH: begin do_enter = 1'b1; ent = PH_RA_LOW; end
					PH_RA_LOW: begin
						if (ackc_q) n_sda = 1'b1;
						n_rx = shift_q;
						done = 1'b1;
					end
					default: done = 1'b1;
				endcase
			end
		end

		// Apply the pin levels and length of the phase being entered
		if (do_enter) begin
			n_phase = ent;
			unique case (ent)
				PH_ST_A: begin
					n_dir = 1'b1; n_sda = 1'b1; n_scl = 1'b1; n_delay = unit2;
				end
				PH_ST_B: begin n_sda = 1'b0; n_delay = unit2; end
				PH_ST_C: begin n_scl = 1'b0; n_delay = unit2; end
				PH_SP_A: begin
					n_dir = 1'b1; n_scl = 1'b0; n_sda = 1'b0; n_delay = unit2;
				end
				PH_SP_B: begin n_scl = 1'b1; n_delay = unit2; end
				PH_SP_C: begin n_sda = 1'b1; n_delay = unit2; end
				PH_WR_LOW: begin n_dir = 1'b1; n_scl = 1'b0; n_delay = unit1; end
				PH_WR_DATA: begin
					n_sda   = n_shift[7];
					n_shift = {n_shift[6:0], 1'b0};
					n_delay = unit1;
				end
				PH_WR_HIGH: begin n_scl = 1'b1; n_delay = unit1; end
				PH_AK_REL:  begin n_dir = 1'b0; n_sda = 1'b1; n_delay = unit1; end
				PH_AK_HIGH: begin n_scl = 1'b1; n_delay = unit1; end
				PH_AK_WAIT: begin n_wait = 17'd0; n_delay = 17'd0; end
				PH_AK_LOW:  begin n_scl = 1'b0; n_delay = unit1; end
				PH_RD_HIGH: begin n_dir = 1'b0; n_scl = 1'b1; n_delay = unit1; end
				PH_RD_LOW:  begin n_scl = 1'b0; n_delay = unit1; end
				PH_RA_DATA: begin n_dir = 1'b1; n_sda = ~n_ackc; n_delay = unit1; end
				PH_RA_HIGH: begin n_scl = 1'b1; n_delay = unit1; end
				PH_RA_LOW:  begin n_scl = 1'b0; n_delay = unit1; end
				default: begin n_phase = PH_IDLE; n_delay = 17'd0; end
			endcase
		end

		// Drop back to idle when the command ends
		if (done) begin
			n_phase = PH_IDLE;
			n_delay = 17'd0;
		end
	end

	// Advance the state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			delay_q <= 17'd0;
			wait_q  <= 17'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			dir_q   <= 1'b1;
			rx_q    <= 8'd0;
			ack_q   <= 1'b1;
			ackc_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			delay_q <= n_delay;
			wait_q  <= n_wait;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			dir_q   <= n_dir;
			rx_q    <= n_rx;
			ack_q   <= n_ack;
			ackc_q  <= n_ackc;
		end
	end

	assign res.scl_level = n_scl;
	assign res.sda_level = n_sda;
	assign res.sda_drive = n_dir;
	assign res.busy_res  = (n_phase != PH_IDLE);
	assign res.done_res  = done;
	assign res.rx_byte   = n_rx;
	assign res.ack_ok    = n_ack;

endmodule
`default_nettype wire

// ----- hdl/i2cbb_out_reg.sv -----
// Result register between the sequencer and the output channel.
`default_nettype none
module i2cbb_out_reg
	import i2cbb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire out_t res,
	input  wire logic out_ready,
	output logic      out_valid,
	output out_t      out_data
);

	logic valid_q;
	out_t data_q;

	// Hold the result until taken; refill on the same edge it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

// ----- hdl/i2cbb_checker.sv -----
// Port-level checks of the I2C bit-bang master, bound to the top level.
`default_nettype none
module i2cbb_checker
	import i2cbb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire out_t out_data,
	input wire logic out_valid,
	input wire logic out_ready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Input is taken whenever the result register can make room
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the result register");

	// Every accepted item yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// A finishing tick leaves the bus idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done while still busy");

endmodule

bind i2c_bitbang_master_top i2cbb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_data  (out_data),
	.out_valid (out_valid),
	.out_ready (out_ready)
);
`default_nettype wire

// ----- bench/i2cbb_checker.sv -----
`timescale 1ns / 1ps
// Checker for the I2C bit-bang master: tracks ticks and register writes, predicts and compares.
module i2cbb_scoreboard
	import i2cbb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  in_t                        in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output logic                       bus_busy
);

	// Bus sequencer phases
	typedef enum logic [4:0] {
		P_IDLE, P_STA1, P_STA2, P_STA3, P_STO1, P_STO2, P_STO3,
		P_WR_LOW, P_WR_BIT, P_WR_HIGH, P_ACK_REL, P_ACK_HIGH, P_ACK_WAIT, P_ACK_LOW,
		P_RD_HIGH, P_RD_LOW, P_RACK_BIT, P_RACK_HIGH, P_RACK_LOW
	} bus_phase_e;

	// Register copies
	logic [15:0] ticks_per_unit;
	logic [15:0] ack_limit;

	// Predicted sequencer state
	bus_phase_e  bus_phase;
	logic [3:0]  bit_no;
	logic [7:0]  shift_byte;
	logic [16:0] delay_cnt;
	logic [16:0] ack_wait_cnt;
	logic        scl_q;
	logic        sda_q;
	logic        sda_oe;
	logic [7:0]  rx_q;
	logic        ack_q;
	logic        ack_sel;

	out_t pin_words_q[$];
	int   mism;
	int   n_checked;

	// Load a phase length of the given number of delay units; zero ticks counts as one
	function void load_delay(input int units);
		int u;
		u = (ticks_per_unit == '0) ? 1 : int'(ticks_per_unit);
		delay_cnt = 17'(units * u);
	endfunction

	// Enter a phase and apply its pin levels
	function void enter_phase(input bus_phase_e p);
		bus_phase = p;
		case (p)
			P_STA1: begin
				sda_oe = 1'b1; sda_q = 1'b1; scl_q = 1'b1; load_delay(2);
			end
			P_STA2: begin
				sda_q = 1'b0; load_delay(2);
			end
			P_STA3: begin
				scl_q = 1'b0; load_delay(2);
			end
			P_STO1: begin
				sda_oe = 1'b1; scl_q = 1'b0; sda_q = 1'b0; load_delay(2);
			end
			P_STO2: begin
				scl_q = 1'b1; load_delay(2);
			end
			P_STO3: begin
				sda_q = 1'b1; load_delay(2);
			end
			P_WR_LOW: begin
				sda_oe = 1'b1; scl_q = 1'b0; load_delay(1);
			end
			P_WR_BIT: begin
				sda_q = shift_byte[7];
				shift_byte = {shift_byte[6:0], 1'b0};
				load_delay(1);
			end
			P_WR_HIGH: begin
				scl_q = 1'b1; load_delay(1);
			end
			P_ACK_REL: begin
				sda_oe = 1'b0; sda_q = 1'b1; load_delay(1);
			end
			P_ACK_HIGH: begin
				scl_q = 1'b1; load_delay(1);
			end
			P_ACK_WAIT: begin
				ack_wait_cnt = '0; delay_cnt = '0;
			end
			P_ACK_LOW: begin
				scl_q = 1'b0; load_delay(1);
			end
			P_RD_HIGH: begin
				sda_oe = 1'b0; scl_q = 1'b1; load_delay(1);
			end
			P_RD_LOW: begin
				scl_q = 1'b0; load_delay(1);
			end
			P_RACK_BIT: begin
				sda_oe = 1'b1; sda_q = ~ack_sel; load_delay(1);
			end
			P_RACK_HIGH: begin
				scl_q = 1'b1; load_delay(1);
			end
			P_RACK_LOW: begin
				scl_q = 1'b0; load_delay(1);
			end
			default: begin
				bus_phase = P_IDLE; delay_cnt = '0;
			end
		endcase
	endfunction

	// Move on when a phase runs out; returns 1 when the command ends
	function logic next_phase(input logic sda_in);
		next_phase = 1'b0;
		case (bus_phase)
			P_STA1: enter_phase(P_STA2);
			P_STA2: enter_phase(P_STA3);
			P_STO1: enter_phase(P_STO2);
			P_STO2: enter_phase(P_STO3);
			P_WR_LOW: enter_phase(P_WR_BIT);
			P_WR_BIT: enter_phase(P_WR_HIGH);
			P_WR_HIGH: begin
				if (bit_no < 4'd7) begin
					bit_no = bit_no + 4'd1;
					enter_phase(P_WR_LOW);
				end else begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					if (ack_sel)
						enter_phase(P_ACK_REL);
					else
						next_phase = 1'b1;
				end
			end
			P_ACK_REL: enter_phase(P_ACK_HIGH);
			P_ACK_HIGH: enter_phase(P_ACK_WAIT);
			P_RD_HIGH: begin
				shift_byte = {shift_byte[6:0], sda_in};
				enter_phase(P_RD_LOW);
			end
			P_RD_LOW: begin
				if (bit_no < 4'd7) begin
					bit_no = bit_no + 4'd1;
					enter_phase(P_RD_HIGH);
				end else begin
					enter_phase(P_RACK_BIT);
				end
			end
			P_RACK_BIT: enter_phase(P_RACK_HIGH);
			P_RACK_HIGH: enter_phase(P_RACK_LOW);
			P_RACK_LOW: begin
				if (ack_sel)
					sda_q = 1'b1;
				rx_q = shift_byte;
				next_phase = 1'b1;
			end
			default: next_phase = 1'b1;
		endcase
	endfunction

	// Advance the predicted master by one tick and return the pin word it shows
	function out_t next_pins(input in_t t);
		logic done;
		out_t r;
		done = 1'b0;
		if (bus_phase == P_IDLE) begin
			if (t.cmd >= CMD_START && t.cmd <= CMD_READ) begin
				bit_no = '0;
				ack_wait_cnt = '0;
				ack_sel = t.ack_mode;
				ack_q = 1'b1;
				shift_byte = (t.cmd == CMD_WRITE) ? t.tx_byte : 8'h00;
				case (t.cmd)
					CMD_START: enter_phase(P_STA1);
					CMD_STOP:  enter_phase(P_STO1);
					CMD_WRITE: enter_phase(P_WR_LOW);
					default:   enter_phase(P_RD_HIGH);
				endcase
			end
		end else if (bus_phase == P_ACK_WAIT) begin
			// low SDA is the acknowledge; too many high samples end the write
			if (!t.sda_in) begin
				enter_phase(P_ACK_LOW);
			end else if (ack_wait_cnt > {1'b0, ack_limit}) begin
				scl_q = 1'b0;
				ack_q = 1'b0;
				done = 1'b1;
			end else begin
				ack_wait_cnt = ack_wait_cnt + 17'd1;
			end
		end else begin
			if (delay_cnt > 0)
				delay_cnt = delay_cnt - 17'd1;
			if (delay_cnt == 0)
				done = next_phase(t.sda_in);
		end
		if (done) begin
			bus_phase = P_IDLE;
			delay_cnt = '0;
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.sda_drive = sda_oe;
		r.busy_res  = (bus_phase != P_IDLE);
		r.done_res  = done;
		r.rx_byte   = rx_q;
		r.ack_ok    = ack_q;
		return r;
	endfunction

	// Follow register writes, accepted ticks and accepted results
	always @(posedge clk or negedge arst_n) begin : track
		out_t want;
		if (!arst_n) begin
			ticks_per_unit = UNIT_TICKS_RST;
			ack_limit = ACK_TIMEOUT_RST;
			bus_phase = P_IDLE;
			bit_no = '0;
			shift_byte = '0;
			delay_cnt = '0;
			ack_wait_cnt = '0;
			scl_q = 1'b1;
			sda_q = 1'b1;
			sda_oe = 1'b1;
			rx_q = '0;
			ack_q = 1'b1;
			ack_sel = 1'b0;
			pin_words_q.delete();
			mism = 0;
			n_checked = 0;
			fail_count <= 0;
			pending <= 0;
			bus_busy <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_UNIT_TICKS)
					ticks_per_unit = cfg_data;
				else if (cfg_index == CFG_ACK_TIMEOUT)
					ack_limit = cfg_data;
			end
			// compare a result with the oldest prediction
			if (out_valid && out_ready) begin
				if (pin_words_q.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected result at %0t: %h", $realtime, out_data);
				end else begin
					want = pin_words_q.pop_front();
					if (out_data !== want) begin
						mism++;
						if (mism <= 10) begin
							$write("result %0d mismatch (expected/actual): scl %b/%b sda %b/%b ",
								n_checked,
								want.scl_level, out_data.scl_level,
								want.sda_level, out_data.sda_level);
							$display("drive %b/%b busy %b/%b done %b/%b rx %h/%h ack %b/%b",
								want.sda_drive, out_data.sda_drive,
								want.busy_res, out_data.busy_res,
								want.done_res, out_data.done_res,
								want.rx_byte, out_data.rx_byte,
								want.ack_ok, out_data.ack_ok);
						end
					end
				end
				n_checked++;
			end
			if (in_valid && in_ready)
				pin_words_q.push_back(next_pins(in_data));
			fail_count <= mism;
			pending <= pin_words_q.size();
			bus_busy <= (bus_phase != P_IDLE);
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the I2C bit-bang master: makes ticks and register writes, gives the verdict.
module tb;
	import i2cbb_pkg::*;

	// Reserved command codes, which the master ignores
	localparam logic [2:0] CMD_RSVD_LO = 3'd5;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;

	typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_UNIT_TICKS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int   send_idle = 27;
	int   recv_idle = 88;
	logic stall_req = 1'b0;
	logic stall_taken = 1'b0;
	int   stall_left = 0;
	int   fail_count;
	int   pending;
	logic bus_busy;

	always #2 clk = ~clk;

	i2c_bitbang_master_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2cbb_scoreboard u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.bus_busy   (bus_busy)
	);

	// Drive the result side: one long hold-off on request, otherwise random idling
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_req && !stall_taken) begin
			out_ready <= 1'b0;
			stall_left <= 300;
			stall_taken <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Give up after a generous time
	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic pick_sda(input sda_mode_e m);
		case (m)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom);
		endcase
	endfunction

	// Build a tick with the given command and random payload
	function automatic in_t tick(input logic [2:0] c, input sda_mode_e m);
		in_t t;
		t.cmd = c;
		t.tx_byte = 8'($urandom);
		t.ack_mode = 1'($urandom);
		t.sda_in = pick_sda(m);
		return t;
	endfunction

	// Mostly no command, some reserved codes, the rest real commands
	function automatic in_t rand_tick(input sda_mode_e m);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return tick(CMD_NONE, m);
		else if (r < 65)
			return tick(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), m);
		else
			return tick(3'($urandom_range(CMD_START, CMD_READ)), m);
	endfunction

	function automatic logic [15:0] pick_unit();
		case ($urandom_range(5))
			0:       return 16'd0;
			1, 2:    return 16'd1;
			3:       return 16'd2;
			4:       return 16'd3;
			default: return 16'($urandom_range(4, 6));
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(9))
			0, 1:    return 16'd0;
			2, 3:    return 16'd1;
			4, 5, 6: return 16'($urandom_range(2, 8));
			7, 8:    return 16'($urandom_range(9, 40));
			default: return 16'hFFFF;
		endcase
	endfunction

	// Offer one tick and hold it until it is taken
	task automatic put_tick(input in_t t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// Send empty ticks until the bus is idle; the busy flag lags one tick behind
	task automatic run_out(input sda_mode_e m);
		do put_tick(tick(CMD_NONE, m)); while (bus_busy);
	endtask

	// Finish the current command and drain every outstanding result
	task automatic quiesce();
		run_out(SDA_RAND);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write both timing registers while the master is idle
	task automatic set_timing(input logic [15:0] ticks, input logic [15:0] limit);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNIT_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Issue one command and run it to its end with the given SDA behaviour
	task automatic issue(input logic [2:0] c, input logic [7:0] tx, input logic am,
			input sda_mode_e m);
		in_t t;
		t.cmd = c;
		t.tx_byte = tx;
		t.ack_mode = am;
		t.sda_in = pick_sda(m);
		put_tick(t);
		run_out(m);
	endtask

	task automatic random_ticks(input int n);
		sda_mode_e m;
		m = SDA_RAND;
		for (int k = 0; k < n; k++) begin
			// change the slave's SDA behaviour every 24 ticks
			if (k % 24 == 0)
				m = sda_mode_e'($urandom_range(2));
			put_tick(rand_tick(m));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero tick count, shortest timeout, every command and ACK outcome
		set_timing(16'd0, 16'd0);
		issue(CMD_START, 8'h00, 1'b0, SDA_RAND);
		issue(CMD_WRITE, 8'hFF, 1'b1, SDA_LOW);
		issue(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH);
		issue(CMD_READ, 8'h5A, 1'b1, SDA_RAND);
		issue(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND);
		issue(CMD_READ, 8'h00, 1'b0, SDA_HIGH);
		issue(CMD_READ, 8'hFF, 1'b1, SDA_LOW);
		issue(CMD_RSVD_LO, 8'hFF, 1'b1, SDA_RAND);
		issue(CMD_RSVD_HI, 8'h00, 1'b0, SDA_RAND);
		issue(CMD_RSVD_LO + 3'd1, 8'h3C, 1'b1, SDA_RAND);
		// a command while busy is dropped
		put_tick(tick(CMD_START, SDA_RAND));
		issue(CMD_WRITE, 8'hC3, 1'b1, SDA_LOW);
		issue(CMD_STOP, 8'h00, 1'b1, SDA_RAND);
		set_timing(16'd1, 16'd3);
		issue(CMD_WRITE, 8'h81, 1'b1, SDA_HIGH);
		issue(CMD_STOP, 8'h00, 1'b0, SDA_RAND);

		// Random: three idling patterns, several register settings each
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle = 27;
					recv_idle <= 88;
				end
				1: begin
					send_idle = 88;
					recv_idle <= 27;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			for (int s = 0; s < 4; s++) begin
				set_timing(pick_unit(), pick_limit());
				if (p == 2 && s == 0)
					stall_req <= 1'b1;
				random_ticks(80);
			end
		end

		// Longer timing: a long ACK wait, then a longer delay unit
		set_timing(16'd1, 16'd60);
		issue(CMD_WRITE, 8'($urandom), 1'b1, SDA_HIGH);
		set_timing(16'd20, 16'd1000);
		issue(CMD_START, 8'($urandom), 1'b0, SDA_RAND);

		// Drain and give the verdict
		quiesce();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- i2c_bitbang_master_top.f -----
hdl/i2cbb_pkg.sv
hdl/i2cbb_cfg.sv
hdl/i2cbb_core.sv
hdl/i2cbb_out_reg.sv
hdl/i2c_bitbang_master_top.sv
hdl/i2cbb_checker.sv
bench/i2cbb_checker.sv
bench/tb.sv
